@@ rtl/sorted_list_insert_delete_defines.svh @@
// ----------------------------------------------------------------------------
// sorted list assertion macros
// shared property shapes for the sorted list checks
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define SLID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list same-cycle check failed");

// next-cycle implication, disabled while reset is active
`define SLID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list next-cycle check failed");

`endif

@@ rtl/slid_pkg.sv @@
// ----------------------------------------------------------------------------
// slid_pkg
// types and codes shared by the sorted list controller and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slid_pkg;

    localparam int KEY_W = 32;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 3;
    localparam int OCC_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_DUMP     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] value;
        logic                    last;
        logic [OCC_W-1:0]        occupancy;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic advance;
        logic show_dump;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] req_cmd;
        logic             is_empty;
        logic             dump_last;
    } sts_t;

endpackage

@@ rtl/slid_datapath.sv @@
// ----------------------------------------------------------------------------
// slid_datapath
// sorted entry cells with parallel compare and shift, request and result regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slid_datapath #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  slid_pkg::ctl_t ctl,
    input  slid_pkg::req_t req,
    output slid_pkg::sts_t sts,
    output slid_pkg::rsp_t rsp
);
    import slid_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    req_t                    req_reg;
    rsp_t                    res_reg;
    rsp_t                    res_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [IDX_W-1:0]        dump_idx_reg;
    logic [IDX_W-1:0]        dump_idx_next;
    logic signed [KEY_W-1:0] entry_reg [DEPTH];
    logic signed [KEY_W-1:0] entry_next [DEPTH];

    logic [DEPTH-1:0] gt;
    logic [DEPTH-1:0] eq;
    logic [DEPTH-1:0] hit_pre;
    logic             full;
    logic             empty;
    logic             found;
    logic             dump_last;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign found     = |eq;
    assign dump_last = (CNT_W'(dump_idx_reg) + CNT_W'(1) == cnt_reg);

    // one compare-and-shift cell per entry
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                    in_use;
        logic                    ins_move;
        logic                    ins_head;
        logic                    del_move;
        logic                    rot_end;
        logic signed [KEY_W-1:0] prev_val;
        logic signed [KEY_W-1:0] next_val;

        assign in_use   = (CNT_W'(g) < cnt_reg);
        // unused cells act as +infinity so the insertion point ends at the count
        assign gt[g]    = in_use ? (req_reg.key < entry_reg[g]) : 1'b1;
        assign eq[g]    = in_use && (entry_reg[g] == req_reg.key);
        assign hit_pre[g] = |eq[g:0];
        assign ins_move = gt[g] && (CNT_W'(g) <= cnt_reg);
        assign del_move = hit_pre[g] && (CNT_W'(g + 1) < cnt_reg);
        assign rot_end  = (CNT_W'(g + 1) == cnt_reg);

        if (g == 0)
        begin : g_first
            assign ins_head = 1'b1;
            assign prev_val = entry_reg[g];
        end
        else
        begin : g_inner
            assign ins_head = !gt[g-1];
            assign prev_val = entry_reg[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign next_val = entry_reg[g];
        end
        else
        begin : g_body
            assign next_val = entry_reg[g+1];
        end

        always_comb
        begin
            entry_next[g] = entry_reg[g];
            if (ctl.execute)
            begin
                case (req_reg.cmd)
                    CMD_INSERT:
                    begin
                        if (!full && ins_move)
                            entry_next[g] = ins_head ? req_reg.key : prev_val;
                    end
                    CMD_DELETE:
                    begin
                        if (found && del_move)
                            entry_next[g] = next_val;
                    end
                    default:
                    begin
                        entry_next[g] = entry_reg[g];
                    end
                endcase
            end
            else if (ctl.advance)
            begin
                // rotate the live entries so the head always holds the next key
                entry_next[g] = rot_end ? entry_reg[0] : next_val;
            end
        end

        always_ff @(posedge clk)
        begin
            entry_reg[g] <= entry_next[g];
        end
    end

    always_comb
    begin
        res_next      = res_reg;
        cnt_next      = cnt_reg;
        dump_idx_next = dump_idx_reg;
        if (ctl.execute)
        begin
            res_next.value = req_reg.key;
            res_next.last  = 1'b1;
            case (req_reg.cmd)
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        res_next.status    = ST_FULL;
                        res_next.occupancy = OCC_W'(cnt_reg);
                    end
                    else
                    begin
                        cnt_next           = cnt_reg + CNT_W'(1);
                        res_next.status    = ST_INSERTED;
                        res_next.occupancy = OCC_W'(cnt_next);
                    end
                end
                CMD_DELETE:
                begin
                    if (empty)
                        res_next.status = ST_EMPTY;
                    else if (!found)
                        res_next.status = ST_NOTFOUND;
                    else
                    begin
                        cnt_next        = cnt_reg - CNT_W'(1);
                        res_next.status = ST_DELETED;
                    end
                    res_next.occupancy = OCC_W'(cnt_next);
                end
                CMD_DUMP:
                begin
                    res_next.status    = ST_EMPTY;
                    res_next.occupancy = OCC_W'(cnt_reg);
                    dump_idx_next      = '0;
                end
                default:
                begin
                    res_next = res_reg;
                end
            endcase
        end
        else if (ctl.advance)
        begin
            dump_idx_next = dump_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            dump_idx_reg <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            dump_idx_reg <= dump_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
            req_reg <= req;
        res_reg <= res_next;
    end

    assign sts.req_cmd   = req_reg.cmd;
    assign sts.is_empty  = empty;
    assign sts.dump_last = dump_last;

    always_comb
    begin
        if (ctl.show_dump)
        begin
            rsp.status    = ST_DUMP;
            rsp.value     = entry_reg[0];
            rsp.last      = dump_last;
            rsp.occupancy = OCC_W'(cnt_reg);
        end
        else
        begin
            rsp = res_reg;
        end
    end

endmodule

@@ rtl/slid_controller.sv @@
// ----------------------------------------------------------------------------
// slid_controller
// request sequencing: accept, execute, respond or stream a dump
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slid_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  slid_pkg::sts_t sts,
    output slid_pkg::ctl_t ctl
);
    import slid_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (sts.req_cmd)
                    CMD_INSERT, CMD_DELETE: state_next = S_RESP;
                    CMD_DUMP:               state_next = sts.is_empty ? S_RESP : S_DUMP;
                    default:                state_next = S_IDLE;
                endcase
            end
            S_RESP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            S_DUMP:
            begin
                if (out_ready && sts.dump_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        ctl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            S_EXEC:
            begin
                ctl.execute = 1'b1;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            S_DUMP:
            begin
                out_valid     = 1'b1;
                ctl.show_dump = 1'b1;
                ctl.advance   = out_ready;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/sorted_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// bounded ascending multiset of signed keys with insert, delete and dump
// ----------------------------------------------------------------------------
// usage:
//   request channel (in_valid/in_ready/in_data) carries cmd and key; the
//   response channel (out_valid/out_ready/out_data) returns status, value,
//   last and occupancy. one request is handled at a time.
//   insert and delete: the request is captured in the idle state, the compare
//   and shift across all entry cells happens in the next cycle, and the
//   response is shown from the cycle after. dump: one response per stored key,
//   one per cycle while out_ready is high; an empty store gives a single empty
//   response. the rate is set by the controller sequence of capture, execute,
//   respond. a stalled receiver holds the response steady and in_ready stays
//   low until the last response of the request is taken.
//   reset empties the store at once (count to zero); entries need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_list_insert_delete_defines.svh"

module sorted_list_insert_delete #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  slid_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output slid_pkg::rsp_t out_data
);
    import slid_pkg::*;

    ctl_t ctl;
    sts_t sts;

    slid_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    slid_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (in_data),
        .sts   (sts),
        .rsp   (out_data)
    );

    // one request in flight: never taking a request while a response is shown
    `SLID_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)

    // a taken request always goes to execution next
    `SLID_ASSERT_NEXT(a_exec_after_take, clk, rst_n, in_valid && in_ready, ctl.execute)

    // a successful insert leaves at least one key stored
    `SLID_ASSERT_NOW(a_insert_occ, clk, rst_n,
        out_valid && (out_data.status == ST_INSERTED), out_data.occupancy != '0)

    // dump elements only while the store holds keys
    `SLID_ASSERT_NOW(a_dump_nonempty, clk, rst_n,
        out_valid && (out_data.status == ST_DUMP), !sts.is_empty)

endmodule

@@ verif/tb_sorted_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete
// Self-checking bench for the sorted key store. A driver takes requests from
// a pending queue. A monitor predicts the responses of every accepted request
// from its own copy of the sorted store and checks each returned response
// against them in order. Both handshake sides idle at random, and once the
// receiver holds off for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;

    import slid_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRESSURE_CYCLES = 150;
    localparam int PRESSURE_AFTER = 40;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 100;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_data;

    // stimulus side
    req_t pending_reqs[$];
    logic signed [KEY_W-1:0] recent_keys[$];
    int reqs_queued = 0;
    int reqs_accepted = 0;
    logic req_taken = 1'b0;
    int unsigned tx_gap = 0;
    logic tx_calm = 1'b0;

    // receive side
    int unsigned rx_stall = 0;
    logic rx_calm = 1'b0;
    logic pressure_done = 1'b0;
    int rsps_seen = 0;

    // predicted store and responses
    logic signed [KEY_W-1:0] model_keys[DEPTH];
    int model_count = 0;
    rsp_t expected_rsps[$];
    rsp_t next_expected;
    int err_count = 0;
    int cycle_count = 0;

    sorted_list_insert_delete #(
        .DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned pick_gap(input logic calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] pool_key(input int idx);
        case (idx)
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'shffff_ffff;
            4: return 32'sh0000_0001;
            5: return 32'shffff_fffe;
            6: return 32'sh0000_0064;
            7: return 32'shffff_ff9c;
            8: return 32'sh7fff_fffe;
            default: return 32'sh8000_0001;
        endcase
    endfunction

    // pool values give duplicates and delete hits, raw draws toggle every bit
    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return pool_key($urandom_range(0, 9));
        if (roll < 65 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return $urandom();
    endfunction

    task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key);
        req_t req;
        req.cmd = cmd;
        req.key = key;
        pending_reqs.push_back(req);
        reqs_queued++;
        if (cmd == CMD_INSERT)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > DEPTH)
                void'(recent_keys.pop_front());
        end
    endtask

    task automatic queue_mix(input int count, input int ins_pct, input int del_pct,
                             input int dump_pct);
        int n;
        int unsigned roll;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                queue_request(CMD_INSERT, pick_key());
            else if (roll < ins_pct + del_pct)
                queue_request(CMD_DELETE, pick_key());
            else if (roll < ins_pct + del_pct + dump_pct)
                queue_request(CMD_DUMP, $urandom());
            else
                queue_request(CMD_UNUSED, $urandom());
        end
    endtask

    // sorted store update and expected responses for one request
    task automatic predict_request(input req_t req);
        rsp_t rsp;
        logic signed [KEY_W-1:0] k;
        int pos;
        int i;
        logic single;
        k = req.key;
        rsp.status = ST_EMPTY;
        rsp.value = k;
        rsp.last = 1'b1;
        single = 1'b1;
        case (req.cmd)
            CMD_INSERT:
            begin
                if (model_count >= DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    // new key goes after every key less than or equal to it
                    pos = 0;
                    while (pos < model_count && !(k < model_keys[pos]))
                        pos++;
                    for (i = model_count; i > pos; i--)
                        model_keys[i] = model_keys[i - 1];
                    model_keys[pos] = k;
                    model_count++;
                    rsp.status = ST_INSERTED;
                end
            end
            CMD_DELETE:
            begin
                if (model_count != 0)
                begin
                    pos = 0;
                    while (pos < model_count && model_keys[pos] !== k)
                        pos++;
                    if (pos >= model_count)
                        rsp.status = ST_NOTFOUND;
                    else
                    begin
                        for (i = pos; i + 1 < model_count; i++)
                            model_keys[i] = model_keys[i + 1];
                        model_count--;
                        rsp.status = ST_DELETED;
                    end
                end
            end
            CMD_DUMP:
            begin
                if (model_count != 0)
                begin
                    single = 1'b0;
                    for (i = 0; i < model_count; i++)
                    begin
                        rsp.status = ST_DUMP;
                        rsp.value = model_keys[i];
                        rsp.last = (i + 1 == model_count);
                        rsp.occupancy = OCC_W'(model_count);
                        expected_rsps.push_back(rsp);
                    end
                end
            end
            default:
                single = 1'b0;
        endcase
        if (single)
        begin
            rsp.occupancy = OCC_W'(model_count);
            expected_rsps.push_back(rsp);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !req_taken))
            ;
        else if (tx_gap != 0)
        begin
            in_valid <= 1'b0;
            tx_gap <= tx_gap - 1;
        end
        else if (pending_reqs.size() != 0)
        begin
            in_data <= pending_reqs.pop_front();
            in_valid <= 1'b1;
            tx_gap <= pick_gap(tx_calm);
        end
        else
            in_valid <= 1'b0;
    end

    // response receiver with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall != 0)
            begin
                out_ready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else if (!pressure_done && rsps_seen >= PRESSURE_AFTER)
            begin
                out_ready <= 1'b0;
                rx_stall <= PRESSURE_CYCLES;
                pressure_done <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    rx_stall <= pick_gap(1'b0);
            end
        end
    end

    // monitor: predict on accepted requests, check returned responses
    always @(posedge clk)
    begin
        req_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_request(in_data);
            reqs_accepted <= reqs_accepted + 1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            rsps_seen <= rsps_seen + 1;
            if (expected_rsps.size() == 0)
            begin
                if (err_count < MAX_REPORTS)
                    $display("%0t: unexpected response: status %0d value %0d last %0d occ %0d",
                             $time, out_data.status, out_data.value, out_data.last,
                             out_data.occupancy);
                err_count <= err_count + 1;
            end
            else
            begin
                next_expected = expected_rsps.pop_front();
                if (out_data.status !== next_expected.status
                    || out_data.value !== next_expected.value
                    || out_data.last !== next_expected.last
                    || out_data.occupancy !== next_expected.occupancy)
                begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: response mismatch: expected status %0d value %0d last %0d occ %0d, got status %0d value %0d last %0d occ %0d",
                                 $time, next_expected.status, next_expected.value,
                                 next_expected.last, next_expected.occupancy,
                                 out_data.status, out_data.value, out_data.last,
                                 out_data.occupancy);
                    err_count <= err_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_sorted_list_insert_delete failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty cases, extremes, duplicates, head and tail removal
        queue_request(CMD_DUMP, 32'sh5a5a_5a5a);
        queue_request(CMD_DELETE, 32'sh0000_1234);
        queue_request(CMD_UNUSED, 32'shffff_ffff);
        queue_request(CMD_INSERT, 32'sh7fff_ffff);
        queue_request(CMD_INSERT, 32'sh8000_0000);
        queue_request(CMD_INSERT, 32'sh0000_0000);
        queue_request(CMD_INSERT, 32'shffff_ffff);
        queue_request(CMD_INSERT, 32'sh0000_0000);
        queue_request(CMD_DUMP, 32'sh0000_0000);
        queue_request(CMD_DELETE, 32'sh0000_0005);
        queue_request(CMD_DELETE, 32'sh0000_0000);
        queue_request(CMD_DELETE, 32'sh8000_0000);
        queue_request(CMD_DELETE, 32'sh7fff_ffff);
        queue_request(CMD_DUMP, 32'sh0000_0000);
        queue_request(CMD_DELETE, 32'sh0000_0000);
        queue_request(CMD_DELETE, 32'shffff_ffff);
        queue_request(CMD_DUMP, 32'sha5a5_a5a5);

        // fill past capacity with random keys, then show the full store
        for (n = 0; n < DEPTH + 2; n++)
            queue_request(CMD_INSERT, pick_key());
        queue_request(CMD_DUMP, $urandom());
        while (pending_reqs.size() != 0)
            @(posedge clk);

        // a stretch with no idling on either side
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        queue_mix(60, 45, 40, 12);
        while (pending_reqs.size() != 0)
            @(posedge clk);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        queue_mix(50, 20, 65, 12);
        queue_mix(50, 70, 15, 12);
        queue_mix(60, 45, 40, 12);
        queue_mix(40, 10, 75, 12);

        while (reqs_accepted != reqs_queued)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("tb_sorted_list_insert_delete passed");
        else
            $display("tb_sorted_list_insert_delete failed");
        $finish;
    end

endmodule
